// ===== rtl/cid_pkg.sv =====
`default_nettype none

package cid_pkg;

	typedef enum logic [2:0] {
		CMD_BEGIN = 3'd0,
		CMD_END   = 3'd1,
		CMD_EI    = 3'd2,
		CMD_DI    = 3'd3,
		CMD_HALT  = 3'd4,
		CMD_WR_IF = 3'd5,
		CMD_WR_IE = 3'd6,
		CMD_RAISE = 3'd7
	} cmd_t;

	localparam logic [6:0]  VEC_BASE        = 7'h40;
	localparam logic [4:0]  DISPATCH_CYCLES = 5'd20;
	localparam logic [4:0]  HALT_CYCLES     = 5'd4;
	localparam logic [15:0] PUSH_DEC        = 16'd2;

	// register byte offsets on the config port
	localparam logic [1:0]  REG_DMG_MODE    = 2'd0;

endpackage

`default_nettype wire

// ===== rtl/cpu_interrupt_dispatch_halt.sv =====
// Flow: an accepted item is held in the input register, and its result is loaded into
// the result register once res_stall lets it advance; res_valid then offers it.
// Throughput: one item per cycle unless res_stall holds the result; the controller
// state is updated in the same cycle the result register loads, so back-to-back
// items see each other's effects. Reset: arst_n clears IF, IE, IME, the EI delay,
// halted and halt-bug flags and all valid bits asynchronously; dmg_mode resets to 1.
`default_nettype none

module cpu_interrupt_dispatch_halt #(
	parameter int NUM_SOURCES = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,

	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  data,
	input  wire logic [15:0] pc_value,
	input  wire logic [15:0] sp_value,

	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             dispatch,
	output logic      [6:0]  vector,
	output logic      [15:0] push_address,
	output logic      [15:0] push_value,
	output logic      [4:0]  stall_cycles,
	output logic             skip_execute,
	output logic             refetch_no_increment,
	output logic             pc_rollback,
	output logic      [7:0]  if_value,
	output logic      [7:0]  ie_value,
	output logic             ime_value
);

	localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam logic [7:0] SRC_MASK = 8'((1 << NUM_SOURCES) - 1);

	// config register
	logic dmg_mode_q;

	assign pready = 1'b1;
	assign prdata = {31'b0, dmg_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmg_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr == cid_pkg::REG_DMG_MODE) begin
				dmg_mode_q <= pwdata[0];
			end
		end
	end

	// controller state
	logic [7:0] if_q;
	logic [7:0] ie_q;
	logic       ime_q;
	logic       ei_pending_q;
	logic       ei_latched_q;
	logic       halted_q;
	logic       halt_bug_q;

	// input register
	logic             valid_s1;
	cid_pkg::cmd_t    command_s1;
	logic [7:0]       data_s1;
	logic [15:0]      pc_s1;
	logic [15:0]      sp_s1;

	logic advance;
	logic fire;

	assign advance   = !res_valid || !res_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			command_s1 <= cid_pkg::cmd_t'(command);
			data_s1    <= data;
			pc_s1      <= pc_value;
			sp_s1      <= sp_value;
		end
	end

	// next-state and result logic
	logic [7:0]       pend;
	logic [IDX_W-1:0] src_idx;
	logic [7:0]       if_d;
	logic [7:0]       ie_d;
	logic             ime_d;
	logic             ei_pending_d;
	logic             ei_latched_d;
	logic             halted_d;
	logic             halt_bug_d;
	logic             disp_d;
	logic [6:0]       vec_d;
	logic [15:0]      paddr_d;
	logic [15:0]      pval_d;
	logic [4:0]       stall_d;
	logic             skip_d;
	logic             refetch_d;
	logic             rollback_d;

	always_comb begin
		pend    = if_q & ie_q & SRC_MASK;
		src_idx = '0;
		for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
			if (pend[i]) begin
				src_idx = IDX_W'(i);
			end
		end

		if_d         = if_q;
		ie_d         = ie_q;
		ime_d        = ime_q;
		ei_pending_d = ei_pending_q;
		ei_latched_d = ei_latched_q;
		halted_d     = halted_q;
		halt_bug_d   = halt_bug_q;
		disp_d       = 1'b0;
		vec_d        = '0;
		paddr_d      = '0;
		pval_d       = '0;
		stall_d      = '0;
		skip_d       = 1'b0;
		refetch_d    = 1'b0;
		rollback_d   = 1'b0;

		case (command_s1)
			cid_pkg::CMD_BEGIN: begin
				if (ime_q && (pend != 8'h00)) begin
					disp_d           = 1'b1;
					vec_d            = cid_pkg::VEC_BASE + 7'({src_idx, 3'b000});
					paddr_d          = sp_s1 - cid_pkg::PUSH_DEC;
					pval_d           = pc_s1;
					stall_d          = cid_pkg::DISPATCH_CYCLES;
					if_d[src_idx]    = 1'b0;
					ime_d            = 1'b0;
					halted_d         = 1'b0;
				end
				ei_latched_d = ei_pending_q;
				ei_pending_d = 1'b0;
				if (halted_d) begin
					stall_d = cid_pkg::HALT_CYCLES;
					skip_d  = 1'b1;
				end else if (halt_bug_q) begin
					refetch_d  = 1'b1;
					halt_bug_d = 1'b0;
				end
			end
			cid_pkg::CMD_END: begin
				if (ei_latched_q) begin
					ime_d        = 1'b1;
					ei_latched_d = 1'b0;
				end
			end
			cid_pkg::CMD_EI: begin
				ei_pending_d = 1'b1;
			end
			cid_pkg::CMD_DI: begin
				ime_d        = 1'b0;
				ei_pending_d = 1'b0;
				ei_latched_d = 1'b0;
			end
			cid_pkg::CMD_HALT: begin
				if (ei_pending_q || ei_latched_q) begin
					// HALT in the EI shadow: enable now and rewind
					ei_pending_d = 1'b0;
					ei_latched_d = 1'b0;
					ime_d        = 1'b1;
					rollback_d   = 1'b1;
				end else if (!ime_q || ((ie_q & SRC_MASK) == 8'h00)) begin
					if (dmg_mode_q) begin
						halt_bug_d = 1'b1;
					end else begin
						stall_d = cid_pkg::HALT_CYCLES;
					end
				end else begin
					halted_d = 1'b1;
				end
			end
			cid_pkg::CMD_WR_IF: begin
				if_d = data_s1;
			end
			cid_pkg::CMD_WR_IE: begin
				ie_d = data_s1;
			end
			cid_pkg::CMD_RAISE: begin
				if_d = if_q | data_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if_q         <= '0;
			ie_q         <= '0;
			ime_q        <= 1'b0;
			ei_pending_q <= 1'b0;
			ei_latched_q <= 1'b0;
			halted_q     <= 1'b0;
			halt_bug_q   <= 1'b0;
			res_valid    <= 1'b0;
		end else begin
			if (fire) begin
				if_q         <= if_d;
				ie_q         <= ie_d;
				ime_q        <= ime_d;
				ei_pending_q <= ei_pending_d;
				ei_latched_q <= ei_latched_d;
				halted_q     <= halted_d;
				halt_bug_q   <= halt_bug_d;
			end
			if (advance) begin
				res_valid <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dispatch             <= disp_d;
			vector               <= vec_d;
			push_address         <= paddr_d;
			push_value           <= pval_d;
			stall_cycles         <= stall_d;
			skip_execute         <= skip_d;
			refetch_no_increment <= refetch_d;
			pc_rollback          <= rollback_d;
			if_value             <= if_d;
			ie_value             <= ie_d;
			ime_value            <= ime_d;
		end
	end

	a_dispatch_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dispatch |->
			stall_cycles == cid_pkg::DISPATCH_CYCLES && !ime_value && !skip_execute)
		else $error("dispatch result inconsistent");

	a_rollback_enables: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pc_rollback |-> ime_value && !dispatch)
		else $error("rollback without master enable");

	a_item_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid)
		else $error("item lost between stages");

	a_halt_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && skip_execute |-> !refetch_no_increment && !dispatch)
		else $error("halted step fetched");

endmodule

`default_nettype wire
